/* hw/rtl/fsd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, widths and helpers for the error diffusion ditherer.
// ----------------------------------------------------------------------------
package fsd_pkg;

	// Payload and register widths.
	localparam int PIX_W      = 8;
	localparam int LWIDTH_W   = 11;
	localparam int THRESH_W   = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// Stored error values are signed sixteenths of a grey level.
	localparam int ERR_W   = 16;
	// Adjusted value and error before saturation.
	localparam int ADJ_W   = 19;
	// Error times a share weight.
	localparam int PROD_W  = 23;
	// Input width of the saturation helper.
	localparam int SAT_IN_W = 24;

	localparam int WHITE_LEVEL = 4080;

	localparam logic [LWIDTH_W-1:0] LWIDTH_RST = LWIDTH_W'(400);
	localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(2040);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_THRESHOLD  = 1'b1
	} cfg_reg_t;

	typedef logic signed [ERR_W-1:0] err_t;

	// Clamp a wide signed value into the stored error range.
	function automatic err_t sat_err(input logic signed [SAT_IN_W-1:0] v);
		err_t r;
		if (v > SAT_IN_W'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -SAT_IN_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = ERR_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fsd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hw/rtl/floyd_steinberg_dither_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_unit
// Floyd-Steinberg error diffusion of 8-bit grey pixels to one bit per pixel.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | sink      | in_valid / in_stall       | pixel_value, frame_start
//   out     | source    | out_valid / out_stall     | dither_bit, line_end
//   cfg     | sink      | cfg_write (no wait)       | cfg_index, cfg_data
//
// One pixel is taken per clock while in_stall is low. A transferred pixel is
// registered into the error stage and its result into the output queue. The
// throughput is set by the error stage: the 7/16 share of one pixel feeds
// the adjusted value of the next pixel. The line memory is read in the
// transfer cycle and written after the error stage. Reset clears the carries,
// the pipeline and the output queue; the line memory needs no clearing pass.
// A stall on the output backs up through a two-entry queue into in_stall.
//
module floyd_steinberg_dither_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                                   clk,
	input  wire                                   arst_n,

	// Pixel input.
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire [fsd_pkg::PIX_W-1:0]              pixel_value,
	input  wire                                   frame_start,

	// Dithered output.
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  dither_bit,
	output logic                                  line_end,

	// Configuration writes.
	input  wire                                   cfg_write,
	input  wire [fsd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [fsd_pkg::CFG_DATA_W-1:0]         cfg_data
);

	// Column index width and the width needed to hold the line width itself.
	localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW1  = $clog2(MAX_WIDTH + 1);
	localparam int LWX  = (CW1 > fsd_pkg::LWIDTH_W) ? CW1 : fsd_pkg::LWIDTH_W;

	localparam int ADJ_W  = fsd_pkg::ADJ_W;
	localparam int PROD_W = fsd_pkg::PROD_W;
	localparam int SAT_W  = fsd_pkg::SAT_IN_W;
	localparam int ERR_W  = fsd_pkg::ERR_W;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [fsd_pkg::LWIDTH_W-1:0] line_width_q;
	logic [fsd_pkg::THRESH_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= fsd_pkg::LWIDTH_RST;
			threshold_q  <= fsd_pkg::THRESH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				fsd_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[fsd_pkg::LWIDTH_W-1:0];
				fsd_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data[fsd_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Transfer stage: column tracking and line memory read.
	// ------------------------------------------------------------------
	logic             in_xfer;
	logic [LWX-1:0]   lw_x;
	logic [LWX-1:0]   w_x;
	logic [XW-1:0]    last_col;
	logic [XW-1:0]    col_cur;
	logic [XW-1:0]    x_s0;
	logic             last_s0;
	logic             first_row_s0;

	logic [XW-1:0]    column_q;
	logic             first_row_q;

	assign in_xfer = in_valid && !in_stall;

	// The width in use is clamped into two pixels up to the memory depth.
	assign lw_x = LWX'(line_width_q);
	always_comb begin
		if (lw_x < LWX'(2)) begin
			w_x = LWX'(2);
		end else if (lw_x > LWX'(MAX_WIDTH)) begin
			w_x = LWX'(MAX_WIDTH);
		end else begin
			w_x = lw_x;
		end
	end
	assign last_col = XW'(w_x - LWX'(1));

	// A column at or past the last one (after a width change) ends the line.
	assign col_cur      = frame_start ? '0 : column_q;
	assign last_s0      = (col_cur >= last_col);
	assign x_s0         = last_s0 ? last_col : col_cur;
	assign first_row_s0 = frame_start || first_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (in_xfer) begin
			column_q    <= last_s0 ? '0 : XW'(x_s0 + XW'(1));
			first_row_q <= last_s0 ? 1'b0 : first_row_s0;
		end
	end

	// Pixel registers for the error stage.
	logic                        valid_s1;
	logic [fsd_pkg::PIX_W-1:0]   pix_s1;
	logic [XW-1:0]               x_s1;
	logic                        last_s1;
	logic                        fs_s1;
	logic                        first_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1       <= pixel_value;
			x_s1         <= x_s0;
			last_s1      <= last_s0;
			fs_s1        <= frame_start;
			first_row_s1 <= first_row_s0;
		end
	end

	// ------------------------------------------------------------------
	// Line memory: errors diffused into the next line, one per column.
	// ------------------------------------------------------------------
	logic              ram_we;
	logic [XW-1:0]     ram_waddr;
	logic [ERR_W-1:0]  ram_wdata;
	logic [ERR_W-1:0]  ram_rdata;

	fsd_ram #(
		.WIDTH (ERR_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (x_s0),
		.rdata (ram_rdata)
	);

	// Regular writes of the left-below entry come one stage after the error
	// stage. The last pixel of a line also leaves the entry below itself; that
	// write waits in the tail register for a cycle with no regular write,
	// which the first pixel of the next line always provides.
	logic              wr_v_s2;
	logic [XW-1:0]     wr_a_s2;
	fsd_pkg::err_t     wr_d_s2;

	logic              tail_v_q;
	logic [XW-1:0]     tail_a_q;
	fsd_pkg::err_t     tail_d_q;

	// The write done in the previous cycle, which the read data cannot show.
	logic              prev_v_q;
	logic [XW-1:0]     prev_a_q;
	logic [ERR_W-1:0]  prev_d_q;

	assign ram_we    = wr_v_s2 || tail_v_q;
	assign ram_waddr = wr_v_s2 ? wr_a_s2 : tail_a_q;
	assign ram_wdata = wr_v_s2 ? wr_d_s2 : tail_d_q;

	// ------------------------------------------------------------------
	// Error stage.
	// ------------------------------------------------------------------
	fsd_pkg::err_t  right_carry_q;
	fsd_pkg::err_t  pend0_q;
	fsd_pkg::err_t  pend1_q;

	fsd_pkg::err_t              above_fwd;
	fsd_pkg::err_t              above;
	fsd_pkg::err_t              carry;
	fsd_pkg::err_t              p0;
	fsd_pkg::err_t              p1;
	logic signed [ADJ_W-1:0]    adj;
	logic                       white;
	logic signed [ADJ_W-1:0]    err;
	logic signed [PROD_W-1:0]   err_x;
	logic signed [PROD_W-1:0]   s7;
	logic signed [PROD_W-1:0]   s5;
	logic signed [PROD_W-1:0]   s3;
	logic signed [PROD_W-1:0]   s1;
	fsd_pkg::err_t              left_below;
	fsd_pkg::err_t              pend0_nxt;
	fsd_pkg::err_t              pend1_nxt;

	// Newest value of the entry being read: a pending tail write first, then
	// the write under way this cycle, then the one just finished.
	always_comb begin
		if (tail_v_q && (tail_a_q == x_s1)) begin
			above_fwd = tail_d_q;
		end else if (wr_v_s2 && (wr_a_s2 == x_s1)) begin
			above_fwd = wr_d_s2;
		end else if (prev_v_q && (prev_a_q == x_s1)) begin
			above_fwd = fsd_pkg::err_t'(prev_d_q);
		end else begin
			above_fwd = fsd_pkg::err_t'(ram_rdata);
		end
	end

	// A frame start drops everything carried from the previous frame.
	assign above = first_row_s1 ? '0 : above_fwd;
	assign carry = fs_s1 ? '0 : right_carry_q;
	assign p0    = fs_s1 ? '0 : pend0_q;
	assign p1    = fs_s1 ? '0 : pend1_q;

	assign adj = $signed(ADJ_W'({pix_s1, 4'b0000})) + ADJ_W'(carry) + ADJ_W'(above);
	assign white = adj > $signed(ADJ_W'(threshold_q));
	assign err = white ? (adj - ADJ_W'(fsd_pkg::WHITE_LEVEL)) : adj;

	// Shares are floored by the arithmetic shift.
	assign err_x = PROD_W'(err);
	assign s7 = (err_x * 23'sd7) >>> 4;
	assign s5 = (err_x * 23'sd5) >>> 4;
	assign s3 = (err_x * 23'sd3) >>> 4;
	assign s1 = err_x >>> 4;

	assign left_below = fsd_pkg::sat_err(SAT_W'(p0) + SAT_W'(s3));
	assign pend0_nxt  = fsd_pkg::sat_err(SAT_W'(p1) + SAT_W'(s5));
	assign pend1_nxt  = last_s1 ? '0 : fsd_pkg::sat_err(SAT_W'(s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_carry_q <= '0;
			pend0_q       <= '0;
			pend1_q       <= '0;
			wr_v_s2       <= 1'b0;
			tail_v_q      <= 1'b0;
			prev_v_q      <= 1'b0;
		end else begin
			prev_v_q <= ram_we;
			wr_v_s2  <= valid_s1 && (x_s1 != '0);

			// A new tail is only made well after the old one has been written.
			if (valid_s1 && last_s1) begin
				tail_v_q <= 1'b1;
			end else if (!wr_v_s2) begin
				tail_v_q <= 1'b0;
			end

			if (valid_s1) begin
				if (last_s1) begin
					right_carry_q <= '0;
					pend0_q       <= '0;
					pend1_q       <= '0;
				end else begin
					right_carry_q <= fsd_pkg::sat_err(SAT_W'(s7));
					pend0_q       <= pend0_nxt;
					pend1_q       <= pend1_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prev_a_q <= ram_waddr;
		prev_d_q <= ram_wdata;
		wr_a_s2  <= XW'(x_s1 - XW'(1));
		wr_d_s2  <= left_below;
		if (valid_s1 && last_s1) begin
			tail_a_q <= x_s1;
			tail_d_q <= pend0_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Output queue, two entries. The error stage never holds a pixel, so a
	// transfer is taken only when the queue will have room for it.
	// ------------------------------------------------------------------
	logic [1:0] count_q;
	logic       q0_bit_q;
	logic       q0_end_q;
	logic       q1_bit_q;
	logic       q1_end_q;
	logic       pop;
	logic [1:0] count_after_pop;
	logic [2:0] occupancy;

	assign pop             = (count_q != 2'd0) && !out_stall;
	assign count_after_pop = count_q - {1'b0, pop};
	assign occupancy       = 3'(count_after_pop) + 3'(valid_s1);
	assign in_stall        = occupancy > 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= 2'(occupancy);
		end
	end

	// A new result goes to the head when the queue is empty after the pop,
	// otherwise behind the head; a pop moves the second entry forward.
	always_ff @(posedge clk) begin
		if (valid_s1 && (count_after_pop == 2'd0)) begin
			q0_bit_q <= white;
			q0_end_q <= last_s1;
		end else if (pop) begin
			q0_bit_q <= q1_bit_q;
			q0_end_q <= q1_end_q;
		end
		if (valid_s1 && (count_after_pop != 2'd0)) begin
			q1_bit_q <= white;
			q1_end_q <= last_s1;
		end
	end

	assign out_valid  = (count_q != 2'd0);
	assign dither_bit = q0_bit_q;
	assign line_end   = q0_end_q;

endmodule
`default_nettype wire

/* hw/rtl/fsd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the ditherer, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire dither_bit,
	input wire line_end
);

	logic       in_xfer;
	logic       out_xfer;
	logic [2:0] outstanding_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Pixels taken whose results have not yet been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 3'd0;
		end else begin
			outstanding_q <= outstanding_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	// A held result does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dither_bit) && $stable(line_end))
		else $error("output changed while stalled");

	// No result without a pixel behind it.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> outstanding_q != 3'd0)
		else $error("result without a pixel");

	// The error stage and the output queue hold at most two pixels.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd2)
		else $error("more than two pixels in flight");

	// A taken pixel shows a result on the output once it has passed the error stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> ##2 out_valid)
		else $error("result missing two cycles after transfer");

endmodule

bind floyd_steinberg_dither_unit fsd_checker u_fsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.dither_bit (dither_bit),
	.line_end   (line_end)
);
`default_nettype wire

/* verif/tb_floyd_steinberg_dither_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_floyd_steinberg_dither_unit
// Self-checking testbench for the Floyd-Steinberg error diffusion ditherer.
// ----------------------------------------------------------------------------
// Pixels are pushed through the input channel with random gaps while the
// output channel is stalled at random. A scoreboard keeps its own copy of the
// carried errors and of the line memory, predicts the dither bit and the
// line-end flag of every pixel transfer, and compares each output transfer
// with the oldest prediction. Register writes are made only once every
// predicted output has been seen, so the pipeline is empty when they land.
// ----------------------------------------------------------------------------
module tb_floyd_steinberg_dither_unit;

	localparam int MAX_COLS       = 1024;
	// Random pixel transfers, the last part of them with no gaps or stalls.
	localparam int RANDOM_PIXELS  = 1150;
	localparam int QUIET_PIXELS   = 150;
	// Cycles without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	// Extra cycles waited after every predicted output has been seen.
	localparam int DRAIN_CYCLES   = 4;

	// The scoreboard predicts the block from its own copy of the state and
	// holds the dither results that are still to come out.
	class dither_scoreboard;
		typedef struct {
			logic white;
			logic last;
		} dither_out_t;

		dither_out_t                  expected_bits[$];
		int                           row_error[];
		bit                           row_written[];
		int                           right_carry;
		int                           below_cur;
		int                           below_next;
		int unsigned                  column;
		bit                           first_row;
		logic [fsd_pkg::LWIDTH_W-1:0] line_width;
		logic [fsd_pkg::THRESH_W-1:0] threshold;
		int unsigned                  max_cols;
		int                           errors;

		function void reset_state(int unsigned cols);
			max_cols    = cols;
			row_error   = new[cols];
			row_written = new[cols];
			right_carry = 0;
			below_cur   = 0;
			below_next  = 0;
			column      = 0;
			first_row   = 1'b1;
			line_width  = fsd_pkg::LWIDTH_RST;
			threshold   = fsd_pkg::THRESH_RST;
			errors      = 0;
		endfunction

		function void write_config(fsd_pkg::cfg_reg_t idx,
			logic [fsd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fsd_pkg::REG_LINE_WIDTH: line_width = data[fsd_pkg::LWIDTH_W-1:0];
				fsd_pkg::REG_THRESHOLD:  threshold  = data[fsd_pkg::THRESH_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_width();
			int unsigned w;
			w = line_width;
			if (w < 2) w = 2;
			if (w > max_cols) w = max_cols;
			return w;
		endfunction

		function int clamp_err(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		// Share of an error in sixteenths, rounded toward minus infinity.
		function int share(int err, int k);
			int p;
			p = err * k;
			return p >>> 4;
		endfunction

		function void store_below(int unsigned x, int v);
			row_error[x]   = v;
			row_written[x] = 1'b1;
		endfunction

		// True when the next pixel, sent without a frame start, would read a
		// line memory entry that has never been written.
		function bit needs_frame_start();
			int unsigned w;
			int unsigned x;
			w = active_width();
			x = (column >= w) ? w - 1 : column;
			return !first_row && !row_written[x];
		endfunction

		function void predict_pixel(logic [fsd_pkg::PIX_W-1:0] pix, logic fs);
			int unsigned w;
			int unsigned x;
			int          above;
			int          adj;
			int          err;
			bit          white;
			bit          last;
			w = active_width();
			if (fs) begin
				right_carry = 0;
				below_cur   = 0;
				below_next  = 0;
				column      = 0;
				first_row   = 1'b1;
			end
			// A width lowered mid-line ends the line at the new last column.
			if (column >= w) column = w - 1;
			x     = column;
			last  = (x + 1 >= w);
			above = first_row ? 0 : row_error[x];
			adj   = 16 * int'(pix) + right_carry + above;
			white = adj > int'(threshold);
			err   = adj - (white ? fsd_pkg::WHITE_LEVEL : 0);
			if (x > 0) store_below(x - 1, clamp_err(below_cur + share(err, 3)));
			below_cur  = clamp_err(below_next + share(err, 5));
			below_next = last ? 0 : clamp_err(share(err, 1));
			if (last) begin
				store_below(x, below_cur);
				below_cur   = 0;
				below_next  = 0;
				right_carry = 0;
				column      = 0;
				first_row   = 1'b0;
			end else begin
				right_carry = clamp_err(share(err, 7));
				column      = x + 1;
			end
			expected_bits.push_back('{white: white, last: last});
		endfunction

		task log_mismatch(string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_result(logic white, logic last);
			dither_out_t want;
			if (expected_bits.size() == 0) begin
				log_mismatch($sformatf("output transfer with no pixel pending (bit %b, end %b)",
					white, last));
			end else begin
				want = expected_bits.pop_front();
				if (white !== want.white)
					log_mismatch($sformatf("dither_bit %b, expected %b", white, want.white));
				if (last !== want.last)
					log_mismatch($sformatf("line_end %b, expected %b", last, want.last));
			end
		endtask
	endclass

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic [fsd_pkg::PIX_W-1:0]      pixel_value = '0;
	logic                           frame_start = 1'b0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic                           dither_bit;
	logic                           line_end;
	logic                           cfg_write   = 1'b0;
	logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index   = fsd_pkg::REG_LINE_WIDTH;
	logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

	dither_scoreboard sb;

	// Chance in percent that the sender leaves a gap before a pixel, and that
	// the receiver starts a stall burst in a given cycle.
	int in_gap_pct    = 0;
	int out_stall_pct = 0;
	int stall_left    = 0;
	int quiet_cycles  = 0;

	floyd_steinberg_dither_unit #(
		.MAX_WIDTH(MAX_COLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_value(pixel_value),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dither_bit(dither_bit),
		.line_end(line_end),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// The receiver stalls in bursts that are independent of out_valid, so they
	// also land on empty cycles.
	always @(posedge clk) begin
		if (stall_left == 0 && $urandom_range(99) < out_stall_pct)
			stall_left = $urandom_range(3, 1);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every output transfer is checked against the oldest prediction. The
	// outputs are read at the edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(dither_bit, line_end);
		end
	end

	// A hung handshake shows up as a long run of cycles with no transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offers one pixel and returns at the edge of its transfer. A frame start
	// is forced where the next line would otherwise read memory that was
	// never written, which can happen once the width has been raised.
	task automatic send_pixel(input logic [fsd_pkg::PIX_W-1:0] pix, input logic fs);
		logic start;
		start = fs;
		if (sb.needs_frame_start()) start = 1'b1;
		if ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= pix;
		frame_start <= start;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.predict_pixel(pix, start);
	endtask

	// Stops sending and waits until every predicted output has come out.
	// The queue is polled on the falling edge so that the monitor's update at
	// the rising edge is already done.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_bits.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fsd_pkg::cfg_reg_t idx,
		input logic [fsd_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.write_config(idx, data);
		@(posedge clk);
	endtask

	initial begin
		int                             pixels_sent;
		int                             count;
		int                             pause_at;
		int                             lo;
		int                             hi;
		int                             roll;
		logic                           fs;
		logic [fsd_pkg::CFG_DATA_W-1:0] wdata;
		logic [fsd_pkg::CFG_DATA_W-1:0] odd_widths [6];

		// Width values outside 2..MAX_WIDTH, the maximum itself, and ones with the
		// unused top bit of the data set: 0, 1, 2047, 1024, 1026 and 2 with bit 11 set.
		odd_widths = '{12'h000, 12'h001, 12'hFFF, 12'h400, 12'hC02, 12'h802};
		pixels_sent = 0;
		sb = new();
		sb.reset_state(MAX_COLS);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of both registers, no frame start. After reset the
		// block is on the first line, so nothing is read from line memory.
		in_gap_pct    = 30;
		out_stall_pct = 30;
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd127, 1'b0);

		// Narrowest line: every pixel is on a line edge. A frame start in
		// the middle of a line drops the carried errors.
		wait_drained();
		write_reg(fsd_pkg::REG_LINE_WIDTH, 12'd2);
		write_reg(fsd_pkg::REG_THRESHOLD, 12'd2040);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);

		// Threshold at white: a full white pixel turns white only through the
		// errors carried into it from earlier pixels.
		wait_drained();
		write_reg(fsd_pkg::REG_THRESHOLD, fsd_pkg::CFG_DATA_W'(fsd_pkg::WHITE_LEVEL));
		write_reg(fsd_pkg::REG_LINE_WIDTH, 12'd3);
		send_pixel(8'd255, 1'b1);
		repeat (5) send_pixel(8'd255, 1'b0);

		// Width zero is taken as two; threshold zero makes any positive
		// adjusted value white.
		wait_drained();
		write_reg(fsd_pkg::REG_LINE_WIDTH, 12'h000);
		write_reg(fsd_pkg::REG_THRESHOLD, 12'h000);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);

		// All data bits set: the width saturates to the maximum and the
		// threshold sits above white. The next phase may lower the width while
		// this long line is still open.
		wait_drained();
		write_reg(fsd_pkg::REG_LINE_WIDTH, 12'hFFF);
		write_reg(fsd_pkg::REG_THRESHOLD, 12'hFFF);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd128, 1'b0);

		// Random phases. Each one drains, may rewrite either register, and
		// then sends a run of mostly continuous lines with random content and
		// an occasional frame start as noise.
		while (pixels_sent < RANDOM_PIXELS - QUIET_PIXELS) begin
			wait_drained();
			roll = $urandom_range(19);
			if (roll == 0) begin
				wdata = odd_widths[$urandom_range(5)];
				count = $urandom_range(40, 10);
			end else if (roll <= 3) begin
				wdata = fsd_pkg::CFG_DATA_W'($urandom_range(96, 17));
				count = $urandom_range(160, 60);
			end else begin
				wdata = fsd_pkg::CFG_DATA_W'($urandom_range(16, 2));
				count = $urandom_range(80, 20);
			end
			if (roll == 0 || $urandom_range(3) != 0)
				write_reg(fsd_pkg::REG_LINE_WIDTH, wdata);
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(5))
					0: wdata = '0;
					1: wdata = fsd_pkg::CFG_DATA_W'(fsd_pkg::WHITE_LEVEL);
					2: wdata = '1;
					default: wdata = fsd_pkg::CFG_DATA_W'($urandom_range(4095));
				endcase
				write_reg(fsd_pkg::REG_THRESHOLD, wdata);
			end

			// Dark, bright, mid-grey or full-range content.
			case ($urandom_range(4))
				0: begin
					lo = 0;
					hi = 31;
				end
				1: begin
					lo = 224;
					hi = 255;
				end
				2: begin
					lo = 96;
					hi = 160;
				end
				default: begin
					lo = 0;
					hi = 255;
				end
			endcase

			// Some phases run without any gaps or stalls on one or both sides.
			case ($urandom_range(2))
				0: in_gap_pct = 0;
				1: in_gap_pct = 15;
				default: in_gap_pct = 40;
			endcase
			case ($urandom_range(2))
				0: out_stall_pct = 0;
				1: out_stall_pct = 15;
				default: out_stall_pct = 40;
			endcase

			// Now and then the sender holds off mid-phase until the block
			// has emptied.
			pause_at = ($urandom_range(3) == 0) ? $urandom_range(count - 1, 1) : -1;
			for (int i = 0; i < count; i++) begin
				if (i == pause_at) wait_drained();
				fs = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(63) == 0);
				send_pixel(fsd_pkg::PIX_W'($urandom_range(hi, lo)), fs);
			end
			pixels_sent += count;
		end

		// Last part: back-to-back transfers with no gaps and no stalls.
		in_gap_pct    = 0;
		out_stall_pct = 0;
		wait_drained();
		write_reg(fsd_pkg::REG_LINE_WIDTH, fsd_pkg::CFG_DATA_W'($urandom_range(40, 2)));
		write_reg(fsd_pkg::REG_THRESHOLD, fsd_pkg::CFG_DATA_W'($urandom_range(4095)));
		for (int i = 0; i < QUIET_PIXELS; i++) begin
			send_pixel(fsd_pkg::PIX_W'($urandom_range(255)), i == 0);
		end

		wait_drained();
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_bits.size() != 0)
			sb.log_mismatch("pixel transfers left without an output transfer");
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
